@@ rtl/cce_ra_pkg.sv @@
// Package for the control channel slot allocator: sizes, beat structs, FSM codes.
// Depends on nothing; imported by every module of the block but cce_ra_ram.
package cce_ra_pkg;

	localparam int SLOTS     = 128;
	localparam int MAX_USERS = 64;
	localparam int MAX_CANDS = 6;
	localparam int MAX_SIZE  = 8;
	localparam int MAX_REL   = 8;

	localparam int SLOT_W = 7;
	localparam int LIM_W  = 8;
	localparam int ID_W   = 7;
	localparam int UIDX_W = 6;
	localparam int SIZE_W = 4;
	localparam int CNT_W  = 3;
	localparam int REL_W  = 4;
	localparam int RIDX_W = 3;

	typedef logic [SLOTS-1:0] slot_vec_t;
	typedef logic [MAX_CANDS-1:0][SLOT_W-1:0] cand_vec_t;

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   user_id;
		logic [SIZE_W-1:0] user_size;
		logic [CNT_W-1:0]  cand_count;
		logic [SLOT_W-1:0] cand_0;
		logic [SLOT_W-1:0] cand_1;
		logic [SLOT_W-1:0] cand_2;
		logic [SLOT_W-1:0] cand_3;
		logic [SLOT_W-1:0] cand_4;
		logic [SLOT_W-1:0] cand_5;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   owner_id;
		logic              placed;
		logic [SLOT_W-1:0] start_slot;
		logic [LIM_W-1:0]  filled_count;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [SIZE_W-1:0] size;
		cand_vec_t         cands;
	} user_row_t;

	typedef struct packed {
		cand_vec_t         cands;
		logic [CNT_W-1:0]  cnt;
		logic [SIZE_W-1:0] size;
		logic [LIM_W-1:0]  lim;
		slot_vec_t         blocked;
	} fit_req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] start;
	} fit_rsp_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FIT    = 8'b0000_0010,
		ST_TRY    = 8'b0000_0100,
		ST_SCAN   = 8'b0000_1000,
		ST_OWN    = 8'b0001_0000,
		ST_USR    = 8'b0010_0000,
		ST_COMMIT = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	localparam logic ACT_NEW_ROUND = 1'b0;
	localparam logic KIND_USER     = 1'b0;
	localparam logic KIND_RELOC    = 1'b1;

	function automatic slot_vec_t span_mask(input logic [SLOT_W-1:0] start,
			input logic [SIZE_W-1:0] size);
		slot_vec_t m;
		m = (slot_vec_t'(1) << size) - slot_vec_t'(1);
		return m << start;
	endfunction

endpackage

@@ rtl/cce_ra_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cce_ra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cce_ra_lane.sv @@
// One candidate lane: checks that a span lies inside the active slots and is free.
// Depends on cce_ra_pkg.
module cce_ra_lane
	import cce_ra_pkg::*;
(
	input  logic              en,
	input  logic [SLOT_W-1:0] cand,
	input  logic [SIZE_W-1:0] size,
	input  logic [LIM_W-1:0]  lim,
	input  slot_vec_t         blocked,
	output logic              fit
);

	slot_vec_t             shifted;
	logic [MAX_SIZE:0]     size_mask;
	logic [LIM_W-1:0]      span_end;

	always_comb begin
		shifted   = blocked >> cand;
		size_mask = ((MAX_SIZE+1)'(1) << size) - (MAX_SIZE+1)'(1);
		span_end  = LIM_W'(cand) + LIM_W'(size);
		fit = en && (span_end <= lim)
			&& ((shifted[MAX_SIZE-1:0] & size_mask[MAX_SIZE-1:0]) == '0);
	end

endmodule

@@ rtl/cce_ra_fit.sv @@
// First-fit unit: one lane per candidate, then a priority merge to the earliest fit.
// Depends on cce_ra_pkg and cce_ra_lane.
module cce_ra_fit
	import cce_ra_pkg::*;
(
	input  fit_req_t req,
	output fit_rsp_t rsp
);

	logic [MAX_CANDS-1:0] fit;

	for (genvar i = 0; i < MAX_CANDS; i++) begin : g_lane
		cce_ra_lane u_lane (
			.en      (CNT_W'(i) < req.cnt),
			.cand    (req.cands[i]),
			.size    (req.size),
			.lim     (req.lim),
			.blocked (req.blocked),
			.fit     (fit[i])
		);
	end

	always_comb begin
		rsp.found = |fit;
		rsp.start = '0;
		for (int i = MAX_CANDS - 1; i >= 0; i--) begin
			if (fit[i]) begin
				rsp.start = req.cands[i];
			end
		end
	end

endmodule

@@ rtl/cce_reshuffle_allocator_unit.sv @@
// Top level of the control channel slot allocator with blocker reshuffling.
// Depends on cce_ra_pkg, cce_ra_ram and cce_ra_fit.
//
//  channel   signals                       direction  handshake
//  item      start, busy, item             in         start & !busy
//  result    result_valid, result          out        one-cycle strobe
//  config    cfg_valid, cfg_ready, cfg_data in        valid & ready
//
// New round: cleared in IDLE alone. Reject: IDLE, then one EMIT beat. First-fit hit: FIT, COMMIT per slot, EMIT.
// Reshuffle: per candidate TRY, SCAN over the span, OWN and USR per blocker, then commit
// writes one slot a cycle (relocated spans plus own span), then one result a cycle.
// The owner RAM has one write port, which sets the commit length.
// Reset clears the slot bitmap, counts and flags; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the last one is out.
module cce_reshuffle_allocator_unit
	import cce_ra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	output logic             result_valid,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LIM_W-1:0] cfg_data
);

	state_t                state_q;
	item_t                 item_q;
	logic [CNT_W-1:0]      cnt_q;
	slot_vec_t             occ_q;
	slot_vec_t             work_occ_q;
	logic [MAX_USERS-1:0]  uplaced_q;
	logic [LIM_W-1:0]      filled_q;
	logic                  full_q;
	logic [LIM_W-1:0]      num_slots_q;
	logic [CNT_W-1:0]      k_q;
	logic [SLOT_W-1:0]     c_q;
	logic [LIM_W-1:0]      j_q;
	logic [REL_W-1:0]      nrel_q;
	logic [ID_W-1:0]       owner_q;
	logic [ID_W-1:0]       rel_id_q    [MAX_REL];
	logic [SLOT_W-1:0]     rel_start_q [MAX_REL];
	logic [SIZE_W-1:0]     rel_size_q  [MAX_REL];
	logic                  ok_q;
	logic [REL_W-1:0]      ri_q;
	logic [SIZE_W-1:0]     wi_q;
	logic [REL_W-1:0]      ei_q;

	logic [LIM_W-1:0]      lim;
	cand_vec_t             in_cands;
	cand_vec_t             q_cands;
	logic [CNT_W-1:0]      in_cnt;
	logic [UIDX_W-1:0]     in_uidx;
	logic [UIDX_W-1:0]     q_uidx;
	logic                  reject;
	slot_vec_t             res_mask;
	logic [LIM_W-1:0]      span_end;
	logic [LIM_W-1:0]      try_end;
	logic [LIM_W-1:0]      filled_next;
	logic [RIDX_W-1:0]     ri;
	logic [RIDX_W-1:0]     ei;
	logic [RIDX_W-1:0]     ni;
	fit_req_t              fit_req;
	fit_rsp_t              fit_rsp;
	user_row_t             row_wdata;
	logic [$bits(user_row_t)-1:0] row_rdata_raw;
	user_row_t             row_rdata;
	logic                  row_we;
	logic [ID_W-1:0]       own_rdata;
	logic                  own_we;
	logic [SLOT_W-1:0]     own_waddr;
	logic [ID_W-1:0]       own_wdata;
	logic [SLOT_W-1:0]     ust_rdata;
	logic                  ust_we;
	logic [UIDX_W-1:0]     ust_waddr;
	logic [SLOT_W-1:0]     ust_wdata;
	logic [UIDX_W-1:0]     usr_raddr;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		lim      = (num_slots_q > LIM_W'(SLOTS)) ? LIM_W'(SLOTS) : num_slots_q;
		in_cands = {item.cand_5, item.cand_4, item.cand_3,
			item.cand_2, item.cand_1, item.cand_0};
		q_cands  = {item_q.cand_5, item_q.cand_4, item_q.cand_3,
			item_q.cand_2, item_q.cand_1, item_q.cand_0};
		in_cnt   = (item.cand_count > CNT_W'(MAX_CANDS)) ? CNT_W'(MAX_CANDS)
			: item.cand_count;
		in_uidx  = UIDX_W'(item.user_id - ID_W'(1));
		q_uidx   = UIDX_W'(item_q.user_id - ID_W'(1));
		reject   = full_q || (item.user_id == '0) || (item.user_id > ID_W'(MAX_USERS))
			|| (item.user_size == '0) || (item.user_size > SIZE_W'(MAX_SIZE));
		if (!reject) begin
			reject = uplaced_q[in_uidx];
		end
		res_mask    = span_mask(c_q, item_q.user_size);
		span_end    = LIM_W'(c_q) + LIM_W'(item_q.user_size);
		try_end     = LIM_W'(q_cands[k_q]) + LIM_W'(item_q.user_size);
		filled_next = filled_q + LIM_W'(item_q.user_size);
		ri          = ri_q[RIDX_W-1:0];
		ei          = ei_q[RIDX_W-1:0];
		ni          = nrel_q[RIDX_W-1:0];
		row_rdata   = user_row_t'(row_rdata_raw);
		usr_raddr   = UIDX_W'(own_rdata - ID_W'(1));
	end

	always_comb begin
		if (state_q == ST_USR) begin
			fit_req.cands   = row_rdata.cands;
			fit_req.cnt     = row_rdata.cnt;
			fit_req.size    = row_rdata.size;
			fit_req.blocked = work_occ_q | res_mask;
		end else begin
			fit_req.cands   = q_cands;
			fit_req.cnt     = cnt_q;
			fit_req.size    = item_q.user_size;
			fit_req.blocked = occ_q;
		end
		fit_req.lim = lim;
	end

	cce_ra_fit u_fit (
		.req (fit_req),
		.rsp (fit_rsp)
	);

	always_comb begin
		row_wdata.cnt   = in_cnt;
		row_wdata.size  = item.user_size;
		row_wdata.cands = in_cands;
		row_we = (state_q == ST_IDLE) && start && (item.action != ACT_NEW_ROUND) && !reject;
		own_we    = (state_q == ST_COMMIT);
		ust_we    = (state_q == ST_COMMIT) && (wi_q == '0);
		if (ri_q < nrel_q) begin
			own_waddr = SLOT_W'(rel_start_q[ri] + SLOT_W'(wi_q));
			own_wdata = rel_id_q[ri];
			ust_waddr = UIDX_W'(rel_id_q[ri] - ID_W'(1));
			ust_wdata = rel_start_q[ri];
		end else begin
			own_waddr = SLOT_W'(c_q + SLOT_W'(wi_q));
			own_wdata = item_q.user_id;
			ust_waddr = q_uidx;
			ust_wdata = c_q;
		end
	end

	cce_ra_ram #(.WIDTH($bits(user_row_t)), .DEPTH(MAX_USERS)) u_user_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (in_uidx),
		.wdata (row_wdata),
		.raddr (usr_raddr),
		.rdata (row_rdata_raw)
	);

	cce_ra_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_waddr),
		.wdata (own_wdata),
		.raddr (j_q[SLOT_W-1:0]),
		.rdata (own_rdata)
	);

	cce_ra_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_USERS)) u_start_ram (
		.clk   (clk),
		.we    (ust_we),
		.waddr (ust_waddr),
		.wdata (ust_wdata),
		.raddr (usr_raddr),
		.rdata (ust_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			uplaced_q   <= '0;
			filled_q    <= '0;
			full_q      <= 1'b0;
			num_slots_q <= LIM_W'(SLOTS);
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_slots_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.action == ACT_NEW_ROUND) begin
							occ_q     <= '0;
							uplaced_q <= '0;
							filled_q  <= '0;
							full_q    <= 1'b0;
						end else if (reject) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_FIT;
						end
					end
				end
				ST_FIT: begin
					state_q <= fit_rsp.found ? ST_COMMIT : ST_TRY;
				end
				ST_TRY: begin
					if (k_q >= cnt_q) begin
						state_q <= ST_EMIT;
					end else if (try_end <= lim) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (j_q >= span_end) begin
						state_q <= ST_COMMIT;
					end else if (work_occ_q[j_q[SLOT_W-1:0]]) begin
						state_q <= (nrel_q == REL_W'(MAX_REL)) ? ST_TRY : ST_OWN;
					end
				end
				ST_OWN: begin
					state_q <= ST_USR;
				end
				ST_USR: begin
					state_q <= fit_rsp.found ? ST_SCAN : ST_TRY;
				end
				ST_COMMIT: begin
					if (ri_q >= nrel_q && wi_q == item_q.user_size - SIZE_W'(1)) begin
						occ_q               <= work_occ_q | res_mask;
						uplaced_q[q_uidx]   <= 1'b1;
						filled_q            <= filled_next;
						full_q              <= full_q || (filled_next >= lim);
						state_q             <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ei_q >= nrel_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= item;
				cnt_q  <= in_cnt;
				ok_q   <= 1'b0;
				nrel_q <= '0;
				ei_q   <= '0;
			end
			ST_FIT: begin
				c_q        <= fit_rsp.start;
				work_occ_q <= occ_q;
				nrel_q     <= '0;
				ri_q       <= '0;
				wi_q       <= '0;
				k_q        <= '0;
			end
			ST_TRY: begin
				if (k_q >= cnt_q) begin
					ok_q   <= 1'b0;
					nrel_q <= '0;
					ei_q   <= '0;
				end else if (try_end <= lim) begin
					c_q        <= q_cands[k_q];
					work_occ_q <= occ_q;
					j_q        <= LIM_W'(q_cands[k_q]);
					nrel_q     <= '0;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_SCAN: begin
				if (j_q >= span_end) begin
					ri_q <= '0;
					wi_q <= '0;
				end else if (!work_occ_q[j_q[SLOT_W-1:0]]) begin
					j_q <= j_q + LIM_W'(1);
				end else if (nrel_q == REL_W'(MAX_REL)) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_OWN: begin
				owner_q <= own_rdata;
			end
			ST_USR: begin
				if (fit_rsp.found) begin
					rel_id_q[ni]    <= owner_q;
					rel_start_q[ni] <= fit_rsp.start;
					rel_size_q[ni]  <= row_rdata.size;
					work_occ_q      <= (work_occ_q & ~span_mask(ust_rdata, row_rdata.size))
						| span_mask(fit_rsp.start, row_rdata.size);
					nrel_q          <= nrel_q + REL_W'(1);
					j_q             <= j_q + LIM_W'(1);
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ST_COMMIT: begin
				if (ri_q < nrel_q) begin
					if (wi_q == rel_size_q[ri] - SIZE_W'(1)) begin
						ri_q <= ri_q + REL_W'(1);
						wi_q <= '0;
					end else begin
						wi_q <= wi_q + SIZE_W'(1);
					end
				end else if (wi_q == item_q.user_size - SIZE_W'(1)) begin
					ok_q <= 1'b1;
					ei_q <= '0;
				end else begin
					wi_q <= wi_q + SIZE_W'(1);
				end
			end
			ST_EMIT: begin
				ei_q <= ei_q + REL_W'(1);
			end
			default: begin
				ei_q <= '0;
			end
		endcase
	end

	always_comb begin
		result_valid        = (state_q == ST_EMIT);
		result.filled_count = filled_q;
		if (ei_q < nrel_q) begin
			result.kind       = KIND_RELOC;
			result.owner_id   = rel_id_q[ei];
			result.placed     = 1'b1;
			result.start_slot = rel_start_q[ei];
			result.last       = 1'b0;
		end else begin
			result.kind       = KIND_USER;
			result.owner_id   = item_q.user_id;
			result.placed     = ok_q;
			result.start_slot = ok_q ? c_q : '0;
			result.last       = 1'b1;
		end
	end

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat outside a busy item");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !busy)
		else $error("busy held after last result beat");

	a_reloc_placed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_RELOC) |-> result.placed && !result.last)
		else $error("relocation beat malformed");

	a_filled_range: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= LIM_W'(SLOTS))
		else $error("occupancy count out of range");

endmodule

@@ tb/tb_cce_reshuffle_allocator_unit.sv @@
// Testbench for cce_reshuffle_allocator_unit: random and directed user placement
// with blocker reshuffling, checked beat by beat against an in-bench predictor.
// Depends on cce_ra_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_cce_reshuffle_allocator_unit;
	import cce_ra_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             result_valid;
	result_t          result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LIM_W-1:0] cfg_data;

	cce_reshuffle_allocator_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// predictor state
	logic [ID_W-1:0]   owner_map [SLOTS];
	logic [SIZE_W-1:0] usr_size [MAX_USERS];
	logic [SLOT_W-1:0] usr_cand [MAX_USERS][MAX_CANDS];
	logic [CNT_W-1:0]  usr_cnt [MAX_USERS];
	int                filled;
	bit                full_flag;
	int                active_slots;
	bit                held [SLOTS];
	bit                vac [SLOTS];

	item_t   pending_items[$];
	result_t expected_beats[$];
	int      errors;
	int      cycles;
	int      n_items;
	int      n_beats;
	int      n_relocs;
	bit      hold_send;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_item(item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic bit span_ok(ref logic [ID_W-1:0] m [SLOTS], input int s, input int sz);
		if (s + sz > active_slots)
			return 0;
		for (int j = s; j < s + sz; j++)
			if (m[j] != 0 || held[j] || vac[j])
				return 0;
		return 1;
	endfunction

	function automatic int place_user(ref logic [ID_W-1:0] m [SLOTS], input int id);
		int idx;
		int c;
		idx = id - 1;
		for (int k = 0; k < usr_cnt[idx]; k++) begin
			c = usr_cand[idx][k];
			if (span_ok(m, c, usr_size[idx])) begin
				for (int j = c; j < c + usr_size[idx]; j++)
					m[j] = ID_W'(id);
				return c;
			end
		end
		return -1;
	endfunction

	function automatic void push_beat(bit kd, int id, bit pl, int st, bit lst);
		result_t r;
		r.kind         = kd;
		r.owner_id     = ID_W'(id);
		r.placed       = pl;
		r.start_slot   = pl ? SLOT_W'(st) : '0;
		r.filled_count = LIM_W'(filled);
		r.last         = lst;
		expected_beats = {expected_beats, r};
	endfunction

	function automatic void allocate_predict(item_t it);
		logic [ID_W-1:0] work [SLOTS];
		int id, sz, cnt, idx, c, at, nrel, o, lo, hi, r;
		int rid [MAX_REL];
		int rst [MAX_REL];
		bit ok;
		logic [SLOT_W-1:0] cv [MAX_CANDS];
		if (it.action == ACT_NEW_ROUND) begin
			foreach (owner_map[j]) owner_map[j] = 0;
			filled = 0;
			full_flag = 0;
			return;
		end
		id = it.user_id;
		sz = it.user_size;
		cnt = it.cand_count;
		if (full_flag || id == 0 || id > MAX_USERS || sz == 0 || sz > MAX_SIZE) begin
			push_beat(KIND_USER, id, 0, 0, 1);
			return;
		end
		foreach (owner_map[j])
			if (owner_map[j] == id) begin
				push_beat(KIND_USER, id, 0, 0, 1);
				return;
			end
		idx = id - 1;
		if (cnt > MAX_CANDS) cnt = MAX_CANDS;
		cv = '{it.cand_0, it.cand_1, it.cand_2, it.cand_3, it.cand_4, it.cand_5};
		usr_size[idx] = SIZE_W'(sz);
		usr_cnt[idx] = CNT_W'(cnt);
		for (int k = 0; k < MAX_CANDS; k++)
			usr_cand[idx][k] = cv[k];
		foreach (held[j]) begin held[j] = 0; vac[j] = 0; end
		at = place_user(owner_map, id);
		nrel = 0;
		for (int k = 0; at < 0 && k < cnt; k++) begin
			ok = 1;
			c = usr_cand[idx][k];
			if (c + sz > active_slots)
				continue;
			work = owner_map;
			foreach (held[j]) begin held[j] = 0; vac[j] = 0; end
			for (int j = c; j < c + sz; j++)
				held[j] = 1;
			nrel = 0;
			for (int j = c; j < c + sz && ok; j++) begin
				o = work[j];
				if (o == 0)
					continue;
				if (nrel >= MAX_REL) begin
					ok = 0;
					break;
				end
				lo = j;
				hi = j;
				while (lo > 0 && work[lo-1] == o) lo--;
				while (hi + 1 < SLOTS && work[hi+1] == o) hi++;
				for (int p = lo; p <= hi; p++) begin
					work[p] = 0;
					vac[p] = 1;
				end
				r = place_user(work, o);
				if (r < 0) begin
					ok = 0;
					break;
				end
				rid[nrel] = o;
				rst[nrel] = r;
				nrel++;
				for (int p = lo; p <= hi; p++)
					vac[p] = 0;
			end
			if (ok) begin
				for (int j = c; j < c + sz; j++)
					work[j] = ID_W'(id);
				owner_map = work;
				at = c;
			end else
				nrel = 0;
		end
		filled = 0;
		foreach (owner_map[j])
			if (owner_map[j] != 0) filled++;
		if (at >= 0 && filled >= active_slots)
			full_flag = 1;
		if (at >= 0)
			for (int k = 0; k < nrel; k++) begin
				push_beat(KIND_RELOC, rid[k], 1, rst[k], 0);
				n_relocs++;
			end
		push_beat(KIND_USER, id, at >= 0, at, 1);
	endfunction

	// driver: bursts and gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				allocate_predict(item);
				n_items++;
			end
			if (start && busy) begin
				// hold the pending beat
			end else if (hold_send || pending_items.size() == 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				end else
					burst_left <= burst_left - 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			cycles++;
			if (result_valid) begin
				n_beats++;
				if (expected_beats.size() == 0) begin
					errors++;
					$error("unexpected result beat owner_id %0d", result.owner_id);
				end else begin
					e = expected_beats.pop_front();
					if (result.kind !== e.kind) begin
						errors++;
						$error("kind exp %0d got %0d", e.kind, result.kind);
					end
					if (result.owner_id !== e.owner_id) begin
						errors++;
						$error("owner_id exp %0d got %0d", e.owner_id, result.owner_id);
					end
					if (result.placed !== e.placed) begin
						errors++;
						$error("placed exp %0d got %0d", e.placed, result.placed);
					end
					if (result.start_slot !== e.start_slot) begin
						errors++;
						$error("start_slot exp %0d got %0d", e.start_slot, result.start_slot);
					end
					if (result.filled_count !== e.filled_count) begin
						errors++;
						$error("filled_count exp %0d got %0d", e.filled_count,
							result.filled_count);
					end
					if (result.last !== e.last) begin
						errors++;
						$error("last exp %0d got %0d", e.last, result.last);
					end
				end
			end
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_cce_reshuffle_allocator_unit: done, errors");
				$finish;
			end
		end
	end

	function automatic item_t mk_user(int id, int sz, int cnt, int c0, int c1, int c2,
			int c3, int c4, int c5);
		item_t it;
		it.action = 1'b1;
		it.user_id = ID_W'(id);
		it.user_size = SIZE_W'(sz);
		it.cand_count = CNT_W'(cnt);
		it.cand_0 = SLOT_W'(c0); it.cand_1 = SLOT_W'(c1); it.cand_2 = SLOT_W'(c2);
		it.cand_3 = SLOT_W'(c3); it.cand_4 = SLOT_W'(c4); it.cand_5 = SLOT_W'(c5);
		return it;
	endfunction

	function automatic item_t mk_round();
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.action = ACT_NEW_ROUND;
		return it;
	endfunction

	// candidates, some aligned to the size, mostly inside the active range
	function automatic int rnd_cand(int sz);
		int c;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 127);
		c = $urandom_range(0, (active_slots > sz ? active_slots - sz : 0));
		if ($urandom_range(0, 1)) c = c - (c % sz);
		return c;
	endfunction

	function automatic item_t rnd_user(int nusers);
		item_t it;
		int sz;
		sz = 1 << $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0) sz = $urandom_range(1, 8);
		it = mk_user($urandom_range(1, nusers), sz, $urandom_range(1, 6),
			rnd_cand(sz), rnd_cand(sz), rnd_cand(sz), rnd_cand(sz), rnd_cand(sz),
			rnd_cand(sz));
		if ($urandom_range(0, 39) == 0) it.user_id = ID_W'($urandom_range(0, 127));
		if ($urandom_range(0, 39) == 0) it.user_size = SIZE_W'($urandom_range(0, 15));
		if ($urandom_range(0, 29) == 0) it.cand_count = CNT_W'($urandom_range(0, 7));
		return it;
	endfunction

	task automatic drain();
		while (pending_items.size() != 0 || start || busy || expected_beats.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_slots(int v);
		@(posedge clk);
		cfg_data <= LIM_W'(v);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_slots = (v < SLOTS) ? v : SLOTS;
	endtask

	initial begin
		int settings [6];
		settings = '{128, 1, 16, 0, 255, 40};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0; cycles = 0; n_items = 0; n_beats = 0; n_relocs = 0;
		hold_send = 0;
		foreach (owner_map[j]) owner_map[j] = 0;
		filled = 0; full_flag = 0; active_slots = 128;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first fit, reshuffle, rejects, edges
		add_item(mk_user(1, 8, 6, 0, 8, 16, 24, 32, 40));
		add_item(mk_user(2, 8, 2, 0, 8, 0, 0, 0, 0));
		add_item(mk_user(3, 8, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_user(3, 4, 1, 4, 0, 0, 0, 0, 0));
		add_item(mk_user(0, 1, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_user(65, 1, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_user(127, 15, 7, 127, 127, 127, 127, 127, 127));
		add_item(mk_user(5, 0, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_user(5, 9, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_user(6, 1, 0, 50, 0, 0, 0, 0, 0));
		add_item(mk_user(7, 8, 7, 127, 121, 120, 60, 61, 62));
		add_item(mk_user(8, 1, 1, 127, 0, 0, 0, 0, 0));
		add_item(mk_user(1, 2, 1, 0, 0, 0, 0, 0, 0));
		add_item(mk_round());
		for (int u = 0; u < 8; u++)
			add_item(mk_user(10 + u, 1, 2, 8 + u, 16 + u, 0, 0, 0, 0));
		add_item(mk_user(30, 8, 1, 8, 0, 0, 0, 0, 0));
		add_item(mk_user(64, 8, 6, 120, 112, 104, 96, 88, 80));
		drain();

		hold_send = 1;
		for (int s = 0; s < 6; s++) begin
			write_slots(settings[s]);
			add_item(mk_round());
			for (int i = 0; i < 44; i++) begin
				if ($urandom_range(0, 24) == 0)
					add_item(mk_round());
				else
					add_item(rnd_user(s == 2 ? 6 : 64));
			end
			hold_send = 0;
			drain();
			hold_send = 1;
		end
		// lower the range mid round so occupancy exceeds it
		write_slots(128);
		hold_send = 0;
		for (int i = 0; i < 20; i++)
			add_item(rnd_user(64));
		drain();
		hold_send = 1;
		write_slots(20);
		hold_send = 0;
		for (int i = 0; i < 10; i++)
			add_item(rnd_user(64));
		drain();

		$display("%0d items, %0d result beats, %0d relocations over 8 slot-count settings",
			n_items, n_beats, n_relocs);
		if (errors == 0 && expected_beats.size() == 0)
			$display("tb_cce_reshuffle_allocator_unit: done, clean");
		else
			$display("tb_cce_reshuffle_allocator_unit: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cce_ra_pkg.sv
rtl/cce_ra_ram.sv
rtl/cce_ra_lane.sv
rtl/cce_ra_fit.sv
rtl/cce_reshuffle_allocator_unit.sv
tb/tb_cce_reshuffle_allocator_unit.sv
